// File: sv/tfr_pkg.sv
// Shared types and constants for the typed frame receiver.
package tfr_pkg;

    // Sync pair that opens every frame
    localparam logic [7:0] SYNC_FIRST  = 8'h06;
    localparam logic [7:0] SYNC_SECOND = 8'h85;

    // Result kinds
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_GOOD     = 3'd1;
    localparam logic [2:0] KIND_BAD_CSUM = 3'd2;
    localparam logic [2:0] KIND_BAD_LEN  = 3'd3;
    localparam logic [2:0] KIND_BAD_TYPE = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_TYPE_COUNT = 3'd0;
    localparam logic [2:0] CFG_SIZE_BASE  = 3'd1;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_HUNT1   = 6'b000001,
        PH_HUNT2   = 6'b000010,
        PH_TYPE    = 6'b000100,
        PH_LEN     = 6'b001000,
        PH_PAYLOAD = 6'b010000,
        PH_CHECK   = 6'b100000
    } t_phase;

    // One registered result request
    typedef struct packed {
        logic       valid;
        logic [2:0] kind;
        logic [1:0] msg_type;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_end;
    } t_result;

endpackage

// File: sv/tfr_parser.sv
// Frame parser state machine with its result register.
module tfr_parser import tfr_pkg::*; #(
    parameter int MAX_TYPES = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [7:0]                 i_rx_byte,
    input  logic [2:0]                 i_limit,
    input  logic [MAX_TYPES-1:0][7:0]  i_sizes,
    output t_result                    o_result,
    input  logic                       i_stall
);

    t_phase     r_phase, n_phase;
    logic [1:0] r_frame_type, n_frame_type;
    logic [7:0] r_frame_length, n_frame_length;
    logic [7:0] r_payload_count, n_payload_count;
    logic [7:0] r_checksum, n_checksum;
    t_result    r_result, n_result;
    logic       accept;
    logic [7:0] type_size;
    logic [7:0] count_inc;

    // Result register frees up when empty or being drained this cycle
    assign o_stall  = r_result.valid & i_stall;
    assign accept   = i_valid & ~o_stall;
    assign o_result = r_result;

    // Configured size of the current frame type
    always_comb begin
        type_size = 8'd0;
        for (int i = 0; i < MAX_TYPES; i++) begin
            if (r_frame_type == 2'(i)) begin
                type_size = i_sizes[i];
            end
        end
    end

    assign count_inc = r_payload_count + 8'd1;

    // Next state and result for one received byte
    always_comb begin
        n_phase         = r_phase;
        n_frame_type    = r_frame_type;
        n_frame_length  = r_frame_length;
        n_payload_count = r_payload_count;
        n_checksum      = r_checksum;
        n_result        = '0;
        case (r_phase)
            PH_HUNT2: begin
                n_phase = (i_rx_byte == SYNC_SECOND) ? PH_TYPE : PH_HUNT1;
            end
            PH_TYPE: begin
                if (i_rx_byte >= {5'd0, i_limit}) begin
                    n_phase            = PH_HUNT1;
                    n_frame_type       = 2'd0;
                    n_frame_length     = 8'd0;
                    n_payload_count    = 8'd0;
                    n_checksum         = 8'd0;
                    n_result.valid     = 1'b1;
                    n_result.kind      = KIND_BAD_TYPE;
                    n_result.frame_end = 1'b1;
                end else begin
                    n_frame_type = i_rx_byte[1:0];
                    n_phase      = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_rx_byte == 8'd0 || i_rx_byte != type_size) begin
                    n_phase            = PH_HUNT1;
                    n_frame_type       = 2'd0;
                    n_frame_length     = 8'd0;
                    n_payload_count    = 8'd0;
                    n_checksum         = 8'd0;
                    n_result.valid     = 1'b1;
                    n_result.kind      = KIND_BAD_LEN;
                    n_result.msg_type  = r_frame_type;
                    n_result.frame_end = 1'b1;
                end else begin
                    n_frame_length  = i_rx_byte;
                    n_checksum      = i_rx_byte;
                    n_payload_count = 8'd0;
                    n_phase         = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                n_result.valid      = 1'b1;
                n_result.kind       = KIND_DATA;
                n_result.msg_type   = r_frame_type;
                n_result.data_byte  = i_rx_byte;
                n_result.byte_index = r_payload_count;
                n_checksum          = r_checksum ^ i_rx_byte;
                n_payload_count     = count_inc;
                if (count_inc >= r_frame_length) begin
                    n_phase = PH_CHECK;
                end
            end
            PH_CHECK: begin
                n_result.valid     = 1'b1;
                n_result.kind      = (i_rx_byte == r_checksum) ? KIND_GOOD : KIND_BAD_CSUM;
                n_result.msg_type  = r_frame_type;
                n_result.frame_end = 1'b1;
                n_phase            = PH_HUNT1;
                n_frame_type       = 2'd0;
                n_frame_length     = 8'd0;
                n_payload_count    = 8'd0;
                n_checksum         = 8'd0;
            end
            default: begin
                // hunting for the first sync byte; stray codes land here too
                n_phase = (i_rx_byte == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_HUNT1;
            r_frame_type    <= 2'd0;
            r_frame_length  <= 8'd0;
            r_payload_count <= 8'd0;
            r_checksum      <= 8'd0;
        end else if (accept) begin
            r_phase         <= n_phase;
            r_frame_type    <= n_frame_type;
            r_frame_length  <= n_frame_length;
            r_payload_count <= n_payload_count;
            r_checksum      <= n_checksum;
        end
    end

    // Result register; only the valid bit is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result.valid <= 1'b0;
        end else if (accept) begin
            r_result.valid <= n_result.valid;
        end else if (!i_stall) begin
            r_result.valid <= 1'b0;
        end
        if (accept) begin
            r_result.kind       <= n_result.kind;
            r_result.msg_type   <= n_result.msg_type;
            r_result.data_byte  <= n_result.data_byte;
            r_result.byte_index <= n_result.byte_index;
            r_result.frame_end  <= n_result.frame_end;
        end
    end

endmodule

// File: sv/typed_frame_receiver_top.sv
// Typed frame receiver: config registers and the frame parser.
//
// Input channel: one received serial byte per request (i_valid, o_stall,
// i_rx_byte). Output channel: at most one result per byte (o_valid,
// i_stall, o_kind, o_msg_type, o_data_byte, o_byte_index, o_frame_end).
// Sync bytes, the type byte and a good length byte give no result;
// payload bytes, checksum bytes and rejected type or length bytes do.
// A result shows on the outputs in the cycle after its byte is taken.
// Throughput: one byte per cycle while o_stall is low, set by the single parser state update;
// a new byte is taken while the previous result is being taken.
// When the receiver stalls with a result pending, o_stall rises and the
// result holds until taken. Reset (synchronous, active low) returns the
// parser to sync hunting, empties the result register and clears all
// configuration, so every type is unknown until type_count and the sizes
// are written. Configuration writes (i_cfg_we) take effect at once and
// are meant to happen only while no frame is in flight.
module typed_frame_receiver_top import tfr_pkg::*; #(
    parameter int MAX_TYPES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_kind,
    output logic [1:0] o_msg_type,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic       o_frame_end,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic [2:0]                r_type_count;
    logic [MAX_TYPES-1:0][7:0] r_sizes;
    logic [2:0]                limit;
    t_result                   result;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_count <= 3'd0;
            r_sizes      <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_TYPE_COUNT) begin
                r_type_count <= i_cfg_data[2:0];
            end
            for (int i = 0; i < MAX_TYPES; i++) begin
                if (i_cfg_index == CFG_SIZE_BASE + 3'(i)) begin
                    r_sizes[i] <= i_cfg_data;
                end
            end
        end
    end

    // Registered types beyond the supported count are ignored
    assign limit = (r_type_count > 3'(MAX_TYPES)) ? 3'(MAX_TYPES) : r_type_count;

    tfr_parser #(
        .MAX_TYPES (MAX_TYPES)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_rx_byte (i_rx_byte),
        .i_limit   (limit),
        .i_sizes   (r_sizes),
        .o_result  (result),
        .i_stall   (i_stall)
    );

    assign o_valid      = result.valid;
    assign o_kind       = result.kind;
    assign o_msg_type   = result.msg_type;
    assign o_data_byte  = result.data_byte;
    assign o_byte_index = result.byte_index;
    assign o_frame_end  = result.frame_end;

endmodule

// File: sv/tfr_checker.sv
// Port-level checks for the typed frame receiver, bound to the top level.
module tfr_checker import tfr_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_kind,
    input logic [1:0] o_msg_type,
    input logic [7:0] o_data_byte,
    input logic [7:0] o_byte_index,
    input logic       o_frame_end
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind) && $stable(o_msg_type)
            && $stable(o_data_byte) && $stable(o_byte_index) && $stable(o_frame_end))
        else $error("stalled result changed");

    // Payload bytes never end a frame
    a_data_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_DATA |-> !o_frame_end)
        else $error("payload byte marked as frame end");

    // Every non-payload result ends the frame with zero data and index
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != KIND_DATA |-> o_frame_end && o_data_byte == 8'd0
            && o_byte_index == 8'd0)
        else $error("frame end result carries data");

    // Unknown type reports type zero
    a_bad_type: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == KIND_BAD_TYPE |-> o_msg_type == 2'd0)
        else $error("unknown type result has nonzero type");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind typed_frame_receiver_top tfr_checker u_tfr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_kind       (o_kind),
    .o_msg_type   (o_msg_type),
    .o_data_byte  (o_data_byte),
    .o_byte_index (o_byte_index),
    .o_frame_end  (o_frame_end)
);
